// ----- hw/rtl/ffba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
  localparam int unsigned PoolBytes = 1048576;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam int unsigned OffW = 20;
  localparam int unsigned LenW = 21;
  // rounded request size, one bit above length so large requests never wrap
  localparam int unsigned SizeW = LenW + 1;
  localparam int unsigned OwnW = 8;
  // packed table entry: owner, free mark, length, offset
  localparam int unsigned EntW = OwnW + 1 + LenW + OffW;

  localparam logic [1:0] FuncAlloc = 2'd0;
  localparam logic [1:0] FuncFree = 2'd1;
  localparam logic [1:0] FuncFreeOwn = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNoFit = 3'd1;
  localparam logic [2:0] StNotAlloc = 3'd2;
  localparam logic [2:0] StZero = 3'd3;
  localparam logic [2:0] StFull = 3'd4;

  typedef struct packed {
    logic [OwnW-1:0] owner;
    logic            is_free;
    logic [LenW-1:0] length;
    logic [OffW-1:0] offset;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_SPLIT, S_MERGE_RD, S_MERGE_CHK, S_FLUSH, S_DONE
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic rd_scan;   // read entry at scan index
    logic rd_shift;  // read entry at shift index - 1
    logic chk;       // evaluate scan entry
    logic adv;       // advance scan index
    logic shift_wr;  // write shifted entry, step down
    logic split;     // write split pair
    logic merge_chk; // one merge step
    logic flush;     // write merge accumulator
    logic fail;      // set status from evaluation failure
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] func;
    logic       zero_req;
    logic       scan_end;  // scan index reached count
    logic       hit;       // entry matches request
    logic       need_split;
    logic       full;
    logic       shift_done;
    logic       owner_hit;
  } stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ffba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire ffba_pkg::stat_t st_i,
  output ffba_pkg::cmd_t      cmd_o
);
  import ffba_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        if (st_i.func == FuncAlloc && st_i.zero_req) state_d = S_DONE;
        else if (st_i.func == FuncAlloc || st_i.func == FuncFree) begin
          state_d = st_i.scan_end ? S_DONE : S_SRCH_CHK;
        end else if (st_i.func == FuncFreeOwn) begin
          state_d = st_i.scan_end ? S_MERGE_RD : S_SRCH_CHK;
        end else state_d = S_DONE;
      end
      S_SRCH_CHK: begin
        if (st_i.func == FuncFreeOwn) state_d = S_SRCH_RD;
        else if (!st_i.hit) state_d = S_SRCH_RD;
        else if (st_i.func == FuncFree) state_d = S_MERGE_RD;
        else if (!st_i.need_split) state_d = S_DONE;
        else if (st_i.full) state_d = S_DONE;
        else state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_d = st_i.shift_done ? S_SPLIT : S_SHIFT_WR;
      S_SHIFT_WR: state_d = S_SHIFT_RD;
      // allocated part still to be written back
      S_SPLIT:    state_d = S_FLUSH;
      S_MERGE_RD: state_d = st_i.scan_end ? S_FLUSH : S_MERGE_CHK;
      S_MERGE_CHK: state_d = S_MERGE_RD;
      S_FLUSH:    state_d = S_DONE;
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SRCH_RD: begin
        cmd_o.rd_scan = 1'b1;
      end
      S_SRCH_CHK: begin
        cmd_o.chk = 1'b1;
        cmd_o.adv = st_i.func == FuncFreeOwn || !st_i.hit;
        cmd_o.fail = st_i.func == FuncAlloc && st_i.hit && st_i.need_split && st_i.full;
      end
      S_SHIFT_RD: cmd_o.rd_shift = 1'b1;
      S_SHIFT_WR: cmd_o.shift_wr = 1'b1;
      S_SPLIT:    cmd_o.split = 1'b1;
      S_MERGE_RD: cmd_o.rd_scan = 1'b1;
      S_MERGE_CHK: cmd_o.merge_chk = 1'b1;
      S_FLUSH:    cmd_o.flush = 1'b1;
      S_DONE:     out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/ffba_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ffba_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ffba_pkg::cmd_t                cmd_i,
  output ffba_pkg::stat_t                    st_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [20:0]                   request_size_i,
  input  wire logic [19:0]                   address_i,
  input  wire logic signed [7:0]             owner_i,
  output logic [2:0]                         status_o,
  output logic [19:0]                        offset_o,
  output logic [20:0]                        granted_size_o,
  output logic [20:0]                        free_bytes_o,
  output logic [6:0]                         blocks_released_o
);
  import ffba_pkg::*;

  // request registers
  logic [1:0]       func_q;
  logic [SizeW-1:0] size_q;
  logic [LenW-1:0]  req_q;
  logic [OffW-1:0]  addr_q;
  logic [OwnW-1:0]  own_q;

  // table control
  logic [CntW-1:0] count_q, count_d;
  logic [LenW-1:0] free_q, free_d;
  logic [CntW-1:0] scan_q, scan_d;   // read index
  logic [CntW-1:0] wr_q, wr_d;       // merge write index
  logic [CntW-1:0] shift_q, shift_d; // shift destination index
  logic [IdxW-1:0] hit_q, hit_d;
  entry_t          hold_q, hold_d;   // hit entry / merge accumulator
  logic            acc_v_q, acc_v_d;

  // result registers
  logic [2:0]      status_q, status_d;
  logic [OffW-1:0] offs_q, offs_d;
  logic [LenW-1:0] gran_q, gran_d;
  logic [6:0]      rel_q, rel_d;

  // memory
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rd;
  logic [EntW-1:0] rdata;

  ffba_ram #(.Width(EntW), .Depth(MaxBlocks)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
  assign rd = entry_t'(rdata);

  // entry 0 is written at reset time by the first access guard below
  logic init_q;

  // read address
  always_comb begin
    if (cmd_i.rd_shift) raddr = IdxW'(shift_q - CntW'(1));
    else raddr = scan_q[IdxW-1:0];
  end

  // evaluation of scanned entry
  logic hit, need_split, owner_hit;
  always_comb begin
    owner_hit = !rd.is_free && rd.owner == own_q;
    case (func_q)
      FuncAlloc: hit = rd.is_free && rd.length >= size_q;
      FuncFree:  hit = !rd.is_free && rd.offset == addr_q;
      default:   hit = owner_hit;
    endcase
    need_split = rd.length > size_q;
  end

  assign st_o.func = func_q;
  assign st_o.zero_req = req_q == '0;
  assign st_o.scan_end = scan_q >= count_q;
  assign st_o.hit = hit;
  assign st_o.need_split = need_split;
  assign st_o.full = count_q >= CntW'(MaxBlocks);
  assign st_o.shift_done = shift_q == CntW'(hit_q) + CntW'(1);
  assign st_o.owner_hit = owner_hit;

  logic adj;
  assign adj = hold_q.is_free && rd.is_free &&
               (LenW'(hold_q.offset) + hold_q.length) == LenW'(rd.offset);

  // datapath next state and memory write
  always_comb begin
    count_d = count_q; free_d = free_q; scan_d = scan_q; wr_d = wr_q;
    shift_d = shift_q; hit_d = hit_q; hold_d = hold_q; acc_v_d = acc_v_q;
    status_d = status_q; offs_d = offs_q; gran_d = gran_q; rel_d = rel_q;
    we = 1'b0; waddr = '0; wdata = rd;
    if (init_q) begin
      we = 1'b1;
      wdata = '{owner: '1, is_free: 1'b1, length: LenW'(PoolBytes), offset: '0};
    end
    if (cmd_i.load) begin
      scan_d = '0;
      status_d = (func_i == FuncAlloc) ?
                 ((request_size_i == '0) ? StZero : StNoFit) :
                 ((func_i == FuncFree) ? StNotAlloc : StOk);
      offs_d = '0; gran_d = '0; rel_d = '0; acc_v_d = 1'b0;
    end
    if (cmd_i.chk) begin
      if (cmd_i.adv) scan_d = scan_q + CntW'(1);
      if (func_q == FuncFreeOwn && owner_hit) begin
        we = 1'b1; waddr = scan_q[IdxW-1:0];
        wdata = rd; wdata.is_free = 1'b1; wdata.owner = '1;
        free_d = free_q + rd.length;
        gran_d = gran_q + rd.length;
        rel_d = rel_q + 7'd1;
      end else if (hit && func_q == FuncFree) begin
        we = 1'b1; waddr = scan_q[IdxW-1:0];
        wdata = rd; wdata.is_free = 1'b1; wdata.owner = '1;
        free_d = free_q + rd.length;
        status_d = StOk; offs_d = rd.offset; gran_d = rd.length; rel_d = 7'd1;
        // merge pass walks the whole table from entry 0
        scan_d = '0;
      end else if (hit && func_q == FuncAlloc) begin
        hit_d = scan_q[IdxW-1:0];
        hold_d = rd;
        shift_d = count_q;
        if (cmd_i.fail) status_d = StFull;
        else if (!need_split) begin
          we = 1'b1; waddr = scan_q[IdxW-1:0];
          wdata = rd; wdata.is_free = 1'b0; wdata.owner = own_q;
          free_d = free_q - LenW'(size_q);
          status_d = StOk; offs_d = rd.offset; gran_d = LenW'(size_q);
        end
      end
    end
    if (cmd_i.shift_wr) begin
      we = 1'b1; waddr = shift_q[IdxW-1:0]; wdata = rd;
      shift_d = shift_q - CntW'(1);
    end
    if (cmd_i.split) begin
      // remainder written here; allocated part goes out in the flush slot
      we = 1'b1; waddr = hit_q + IdxW'(1);
      wdata = '{owner: '1, is_free: 1'b1, length: hold_q.length - LenW'(size_q),
                offset: hold_q.offset + OffW'(size_q)};
      hold_d = '{owner: own_q, is_free: 1'b0, length: LenW'(size_q),
                 offset: hold_q.offset};
      count_d = count_q + CntW'(1);
      free_d = free_q - LenW'(size_q);
      status_d = StOk; offs_d = hold_q.offset; gran_d = LenW'(size_q);
      acc_v_d = 1'b1; wr_d = CntW'(hit_q);
    end
    if (cmd_i.flush) begin
      if (acc_v_q) begin
        we = 1'b1; waddr = wr_q[IdxW-1:0]; wdata = hold_q;
        if (func_q != FuncAlloc) count_d = wr_q + CntW'(1);
      end
    end
    if (cmd_i.load) wr_d = '0;
    // merge pass: restart scan from entry 0 on first read
    if (cmd_i.rd_scan && func_q != FuncAlloc && scan_q >= count_q && !acc_v_q &&
        wr_q == '0 && scan_q != '0) begin
      scan_d = '0;
    end
    if (cmd_i.merge_chk) begin
      scan_d = scan_q + CntW'(1);
      if (!acc_v_q) begin
        hold_d = rd; acc_v_d = 1'b1;
      end else if (adj) begin
        hold_d.length = hold_q.length + rd.length;
      end else begin
        we = 1'b1; waddr = wr_q[IdxW-1:0]; wdata = hold_q;
        wr_d = wr_q + CntW'(1); hold_d = rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntW'(1); free_q <= LenW'(PoolBytes); init_q <= 1'b1;
      scan_q <= '0; wr_q <= '0; shift_q <= '0; acc_v_q <= 1'b0;
    end else begin
      count_q <= count_d; free_q <= free_d; init_q <= 1'b0;
      scan_q <= scan_d; wr_q <= wr_d; shift_q <= shift_d; acc_v_q <= acc_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d; hold_q <= hold_d;
    status_q <= status_d; offs_q <= offs_d; gran_q <= gran_d; rel_q <= rel_d;
    if (cmd_i.load) begin
      func_q <= func_i; req_q <= request_size_i; addr_q <= address_i;
      own_q <= owner_i;
      size_q <= (SizeW'(request_size_i) + SizeW'(7)) & ~SizeW'(7);
    end
  end

  assign status_o = status_q;
  assign offset_o = offs_q;
  assign granted_size_o = gran_q;
  assign free_bytes_o = free_q;
  assign blocks_released_o = rel_q;
endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_block_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// First-fit pool allocator over a 64-entry block table kept in address order.
// Input channel (in_valid_i/in_ready_o) carries one request beat: func,
// request_size, address, owner. Output channel (out_valid_o/out_ready_i)
// returns one result beat per request: status, offset, granted_size,
// free_bytes, blocks_released.
// One request is in flight at a time. A request walks the table in a RAM with
// one write port and a registered read, a read and a check state per entry:
// search, then for an allocate with split a downward shift of the tail (a read
// and a write state per entry) and the split and flush writes, or for a free
// a merge pass over the whole table (a read and a check state per entry) and
// a flush write. Free by owner on a full table is the worst case.
// The result is held in output registers until the receiver takes it; no new
// request is accepted until then; the next can be taken in the cycle after.
// Reset puts one free block covering the whole pool at entry 0; the entry is
// written in the first cycle after reset, and requests may follow at once.
module first_fit_block_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [20:0] request_size_i,
  input  wire logic [19:0] address_i,
  input  wire logic signed [7:0] owner_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [19:0]      offset_o,
  output logic [20:0]      granted_size_o,
  output logic [20:0]      free_bytes_o,
  output logic [6:0]       blocks_released_o
);
  import ffba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  ffba_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .st_i(st), .cmd_o(cmd)
  );

  ffba_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .func_i, .request_size_i, .address_i, .owner_i,
    .status_o, .offset_o, .granted_size_o, .free_bytes_o, .blocks_released_o
  );
endmodule
`default_nettype wire

// ----- test/first_fit_block_allocator_unit_test.sv -----
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_test;
  import ffba_pkg::*;

  localparam int unsigned SizeMask = 32'hFFFF_FFF8;
  localparam logic [1:0] FuncUnused = 2'd3;

  // one request beat
  typedef struct {
    logic [1:0]        func;
    logic [20:0]       request_size;
    logic [19:0]       address;
    logic signed [7:0] owner;
  } alloc_req_t;

  // one result beat
  typedef struct {
    logic [2:0]  status;
    logic [19:0] offset;
    logic [20:0] granted_size;
    logic [20:0] free_bytes;
    logic [6:0]  blocks_released;
  } alloc_res_t;

  // block table image
  typedef struct {
    int unsigned blk_off [MaxBlocks];
    int unsigned blk_len [MaxBlocks];
    bit          blk_free[MaxBlocks];
    bit [7:0]    blk_own [MaxBlocks];
    int unsigned blk_cnt;
    int unsigned free_sum;
  } pool_state_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [1:0]        func_i = FuncAlloc;
  logic [20:0]       request_size_i = '0;
  logic [19:0]       address_i = '0;
  logic signed [7:0] owner_i = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [2:0]        status_o;
  logic [19:0]       offset_o;
  logic [20:0]       granted_size_o;
  logic [20:0]       free_bytes_o;
  logic [6:0]        blocks_released_o;

  alloc_req_t  pending_reqs[$];
  alloc_res_t  expected_results[$];
  pool_state_t dut_pool;
  pool_state_t plan_pool;
  alloc_req_t  cur_req;
  alloc_res_t  pred_res;
  int          mismatches = 0;
  int          queued = 0;
  int          checked = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_ctr = 0;

  first_fit_block_allocator_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .request_size_i    (request_size_i),
    .address_i         (address_i),
    .owner_i           (owner_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .status_o          (status_o),
    .offset_o          (offset_o),
    .granted_size_o    (granted_size_o),
    .free_bytes_o      (free_bytes_o),
    .blocks_released_o (blocks_released_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void pool_clear(ref pool_state_t p);
    for (int i = 0; i < MaxBlocks; i++) begin
      p.blk_off[i] = 0;
      p.blk_len[i] = 0;
      p.blk_free[i] = 1'b0;
      p.blk_own[i] = 8'hFF;
    end
    p.blk_len[0] = PoolBytes;
    p.blk_free[0] = 1'b1;
    p.blk_cnt = 1;
    p.free_sum = PoolBytes;
  endfunction

  // fold neighboring free blocks together
  function automatic void pool_coalesce(ref pool_state_t p);
    int unsigned w;
    w = 0;
    for (int unsigned r = 1; r < p.blk_cnt && r < MaxBlocks; r++) begin
      if (p.blk_free[w] && p.blk_free[r] && p.blk_off[w] + p.blk_len[w] == p.blk_off[r]) begin
        p.blk_len[w] += p.blk_len[r];
      end else begin
        w++;
        p.blk_off[w] = p.blk_off[r];
        p.blk_len[w] = p.blk_len[r];
        p.blk_free[w] = p.blk_free[r];
        p.blk_own[w] = p.blk_own[r];
      end
    end
    p.blk_cnt = w + 1;
  endfunction

  // apply one request to a table image, return the result beat
  function automatic alloc_res_t pool_apply(ref pool_state_t p, input alloc_req_t q);
    alloc_res_t  res;
    int unsigned size;
    int unsigned granted;
    int unsigned released;
    res.status = StOk;
    res.offset = '0;
    granted = 0;
    released = 0;
    size = (int'(q.request_size) + 7) & SizeMask;
    if (q.func == FuncAlloc) begin
      if (q.request_size == 0) begin
        res.status = StZero;
      end else begin
        res.status = StNoFit;
        for (int unsigned i = 0; i < p.blk_cnt && i < MaxBlocks; i++) begin
          if (p.blk_free[i] && p.blk_len[i] >= size) begin
            if (p.blk_len[i] > size) begin
              if (p.blk_cnt >= MaxBlocks) begin
                res.status = StFull;
                break;
              end
              for (int unsigned j = p.blk_cnt; j > i + 1; j--) begin
                p.blk_off[j] = p.blk_off[j-1];
                p.blk_len[j] = p.blk_len[j-1];
                p.blk_free[j] = p.blk_free[j-1];
                p.blk_own[j] = p.blk_own[j-1];
              end
              p.blk_off[i+1] = p.blk_off[i] + size;
              p.blk_len[i+1] = p.blk_len[i] - size;
              p.blk_free[i+1] = 1'b1;
              p.blk_own[i+1] = 8'hFF;
              p.blk_cnt++;
            end
            p.blk_len[i] = size;
            p.blk_free[i] = 1'b0;
            p.blk_own[i] = q.owner;
            p.free_sum -= size;
            res.status = StOk;
            res.offset = p.blk_off[i];
            granted = size;
            break;
          end
        end
      end
    end else if (q.func == FuncFree) begin
      res.status = StNotAlloc;
      for (int unsigned i = 0; i < p.blk_cnt && i < MaxBlocks; i++) begin
        if (!p.blk_free[i] && p.blk_off[i] == q.address) begin
          p.blk_free[i] = 1'b1;
          p.blk_own[i] = 8'hFF;
          p.free_sum += p.blk_len[i];
          res.status = StOk;
          res.offset = p.blk_off[i];
          granted = p.blk_len[i];
          released = 1;
          break;
        end
      end
      if (res.status == StOk) pool_coalesce(p);
    end else if (q.func == FuncFreeOwn) begin
      for (int unsigned i = 0; i < p.blk_cnt && i < MaxBlocks; i++) begin
        if (!p.blk_free[i] && p.blk_own[i] == q.owner) begin
          p.blk_free[i] = 1'b1;
          p.blk_own[i] = 8'hFF;
          p.free_sum += p.blk_len[i];
          granted += p.blk_len[i];
          released++;
        end
      end
      pool_coalesce(p);
    end
    res.granted_size = granted;
    res.free_bytes = p.free_sum;
    res.blocks_released = released;
    return res;
  endfunction

  // queue a request and keep the planning image in step
  task automatic queue_req(input logic [1:0] f, input int unsigned sz,
                           input int unsigned addr, input int own);
    alloc_req_t q;
    alloc_res_t unused_res;
    q.func = f;
    q.request_size = sz;
    q.address = addr;
    q.owner = own;
    unused_res = pool_apply(plan_pool, q);
    pending_reqs.insert(pending_reqs.size(), q);
    queued++;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: bursts with random gaps, predicts on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        pred_res = pool_apply(dut_pool, cur_req);
        expected_results.insert(expected_results.size(), pred_res);
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          func_i <= cur_req.func;
          request_size_i <= cur_req.request_size;
          address_i <= cur_req.address;
          owner_i <= cur_req.owner;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: a random mode is picked whenever the stall counter runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_ctr == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_ctr = 97;
      end
      stall_ctr--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= (stall_ctr % 8) < 5;
      endcase
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    alloc_res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, status", status_o, -1);
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (offset_o !== want.offset) report_mismatch("offset", offset_o, want.offset);
        if (granted_size_o !== want.granted_size)
          report_mismatch("granted_size", granted_size_o, want.granted_size);
        if (free_bytes_o !== want.free_bytes)
          report_mismatch("free_bytes", free_bytes_o, want.free_bytes);
        if (blocks_released_o !== want.blocks_released)
          report_mismatch("blocks_released", blocks_released_o, want.blocks_released);
      end
    end
  end

  initial begin
    int unsigned held[$];
    int          pick;
    pool_clear(dut_pool);
    pool_clear(plan_pool);

    // directed corners
    queue_req(FuncAlloc, 0, 0, 0);                   // zero size
    queue_req(FuncAlloc, PoolBytes, 0, 5);           // exact fit of whole pool
    queue_req(FuncAlloc, 8, 0, 5);                   // no fit
    queue_req(FuncFree, 0, 0, 0);
    queue_req(FuncAlloc, 1, 0, -1);
    queue_req(FuncAlloc, 9, 0, 127);
    queue_req(FuncAlloc, PoolBytes, 0, 2);           // no fit after split
    queue_req(FuncFree, 0, 20'hFFFFF, 0);            // unknown address
    queue_req(FuncFree, 0, 16, 0);                   // address inside an allocated block, not a block start
    queue_req(FuncFreeOwn, 0, 0, 3);                 // owner with no blocks
    queue_req(FuncUnused, 21'h1FFFFF, 20'hFFFFF, -128);
    queue_req(FuncFreeOwn, 0, 0, -1);                // owner -1, the same value that free entries carry
    queue_req(FuncAlloc, 100, 0, 127);
    queue_req(FuncFreeOwn, 0, 0, 127);
    queue_req(FuncAlloc, PoolBytes - 1, 0, 1);       // rounds up to whole pool
    queue_req(FuncFreeOwn, 0, 0, 1);
    queue_req(FuncAlloc, 7, 0, 0);
    queue_req(FuncFree, 0, 0, 0);
    queue_req(FuncAlloc, 21'h1FFFFF, 0, 4);          // largest request field

    // random: mostly small allocations so the table fills up
    repeat (760) begin
      pick = $urandom_range(0, 99);
      held.delete();
      for (int unsigned i = 0; i < plan_pool.blk_cnt; i++)
        if (!plan_pool.blk_free[i]) held.insert(held.size(), plan_pool.blk_off[i]);
      if (pick < 55 || (pick < 82 && held.size() == 0)) begin
        queue_req(FuncAlloc, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200000)
                                                          : $urandom_range(1, 300),
                  $urandom_range(0, 20'hFFFFF), $urandom_range(0, 6) - 1);
      end else if (pick < 82) begin
        queue_req(FuncFree, $urandom_range(0, 21'h1FFFFF),
                  held[$urandom_range(0, held.size() - 1)], $urandom_range(0, 255));
      end else if (pick < 88) begin
        queue_req(FuncFreeOwn, $urandom_range(0, 21'h1FFFFF), $urandom_range(0, 20'hFFFFF),
                  $urandom_range(0, 6) - 1);
      end else begin
        // noise: any func, any field value
        queue_req($urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? 0
                  : $urandom_range(0, 21'h1FFFFF),
                  $urandom_range(0, 20'hFFFFF), $urandom_range(0, 255));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (checked == queued);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("first_fit_block_allocator_unit regression: pass");
    end else begin
      $display("first_fit_block_allocator_unit regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20ns * 2_000_000);
    $display("first_fit_block_allocator_unit regression: fail");
    $finish;
  end
endmodule
